FILE: design/lcgrbd_pkg.sv
// ----------------------------------------------------------------------------
// lcgrbd_pkg: shared constants and codes for the bounded-draw LCG unit
// Operation codes, register indexes, widths and reset values.
// ----------------------------------------------------------------------------
package lcgrbd_pkg;

    localparam int STATE_BITS = 48;
    localparam int SW         = $clog2(STATE_BITS + 1);
    localparam int MAX_DRAWS  = 4096;
    localparam int DRAW_W     = $clog2(MAX_DRAWS + 1);

    localparam logic [47:0] MULT_RESET   = 48'd25214903917;
    localparam logic [47:0] ADDEND_RESET = 48'd11;

    localparam logic [2:0] OP_SEED  = 3'd0;
    localparam logic [2:0] OP_BITS  = 3'd1;
    localparam logic [2:0] OP_INT   = 3'd2;
    localparam logic [2:0] OP_LONG  = 3'd3;
    localparam logic [2:0] OP_BOUND = 3'd4;

    localparam logic [0:0] REG_MULT   = 1'b0;
    localparam logic [0:0] REG_ADDEND = 1'b1;

endpackage

FILE: design/lcg_random_with_bounded_draw_unit.sv
// ----------------------------------------------------------------------------
// lcg_random_with_bounded_draw_unit: 48-bit LCG with bounded draws
// Bit-serial multiplier and restoring divider around one state register.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one operation per item (seed, top bits, int, long, bounded
//   int). m_* returns one result item (value, bad_bound) per input item.
//   cfg_* writes multiplier (index 0) or addend (index 1) while idle;
//   the index is one bit wide, so there are no other indexes.
// Sequencing:
//   One item at a time. Seeding loads the state and goes straight to the
//   output state. Each draw is a shift-add multiply, one multiplier bit per
//   cycle, then the add. A long takes two draws. A bounded int with a non
//   power-of-two bound adds a restoring division per draw, and redraws on
//   rejection up to the draw limit; a power-of-two bound adds no division.
// Reset:
//   State is zero, registers take their standard values, no item pending.
// Stall:
//   The result register holds until m_ready; a new item is taken only
//   after the result is delivered.
// ----------------------------------------------------------------------------
module lcg_random_with_bounded_draw_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_op,
    input  logic [47:0]        s_seed_value,
    input  logic [5:0]         s_bit_count,
    input  logic signed [31:0] s_bound,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [63:0] m_value,
    output logic               m_bad_bound,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [0:0]         cfg_index,
    input  logic [47:0]        cfg_data
);

    localparam int SB = lcgrbd_pkg::STATE_BITS;
    localparam int SW = lcgrbd_pkg::SW;
    localparam int DW = lcgrbd_pkg::DRAW_W;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_ADD, ST_POST, ST_DIV, ST_CHECK, ST_OUT
    } state_t;

    state_t             st_reg;
    logic [47:0]        mult_reg, addend_reg;
    logic [SB-1:0]      lcg_reg;
    logic [SB-1:0]      acc_reg;    // product accumulator
    logic [SB-1:0]      mcand_reg;  // shifted multiplicand
    logic [47:0]        mplier_reg; // multiplier bits, shifted out lsb first
    logic [SW-1:0]      mcnt_reg;
    logic [2:0]         op_reg;
    logic [5:0]         bits_reg;
    logic [31:0]        bound_reg;
    logic               second_reg; // second draw of a long pending
    logic [31:0]        hi_reg;
    logic [30:0]        u_reg;      // draw under test
    logic [31:0]        rem_reg;
    logic [30:0]        quo_reg;    // dividend shifting out msb first
    logic [4:0]         dcnt_reg;
    logic [DW-1:0]      draws_reg;
    logic signed [63:0] value_reg;
    logic               bad_reg;
    logic               mvalid_reg;

    // top 32 bits of the state, and a 31-bit draw
    logic [31:0] top32;
    logic [30:0] top31;
    logic [31:0] bits_val;
    logic [5:0]  bc;
    logic [31:0] rem_shift, rem_sub, chk;
    logic [32:0] rem_diff;
    logic        bound_pow2;

    assign top32 = lcg_reg[SB-1 -: 32];
    assign top31 = lcg_reg[SB-1 -: 31];
    assign bc    = (bits_reg > 6'd32) ? 6'd32 : bits_reg;
    always_comb begin
        if (bc == 6'd0) begin
            bits_val = 32'd0;
        end else begin
            bits_val = top32 >> (6'd32 - bc);
        end
    end
    assign bound_pow2 = ((bound_reg & (bound_reg - 32'd1)) == 32'd0);
    assign rem_shift  = {rem_reg[30:0], quo_reg[30]};
    assign rem_diff   = {1'b0, rem_shift} - {1'b0, bound_reg};
    assign rem_sub    = rem_diff[32] ? rem_shift : rem_diff[31:0];
    assign chk        = {1'b0, u_reg} - rem_reg + bound_reg - 32'd1;

    assign s_ready   = (st_reg == ST_IDLE) && !mvalid_reg;
    assign cfg_ready = (st_reg == ST_IDLE) && !mvalid_reg;
    assign m_valid     = mvalid_reg;
    assign m_value     = value_reg;
    assign m_bad_bound = bad_reg;

    // sequencer, datapath and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg     <= ST_IDLE;
            mult_reg   <= lcgrbd_pkg::MULT_RESET;
            addend_reg <= lcgrbd_pkg::ADDEND_RESET;
            lcg_reg    <= '0;
            mvalid_reg <= 1'b0;
            second_reg <= 1'b0;
        end else begin
            if (mvalid_reg && m_ready) begin
                mvalid_reg <= 1'b0;
            end
            case (st_reg)
                ST_IDLE: begin
                    if (cfg_valid && cfg_ready) begin
                        if (cfg_index == lcgrbd_pkg::REG_MULT) begin
                            mult_reg <= cfg_data;
                        end else begin
                            addend_reg <= cfg_data;
                        end
                    end
                    if (s_valid && s_ready) begin
                        op_reg     <= s_op;
                        bits_reg   <= s_bit_count;
                        bound_reg  <= s_bound;
                        second_reg <= 1'b0;
                        draws_reg  <= DW'(1);
                        value_reg  <= '0;
                        bad_reg    <= 1'b0;
                        acc_reg    <= '0;
                        mcand_reg  <= lcg_reg;
                        mplier_reg <= mult_reg;
                        mcnt_reg   <= '0;
                        case (s_op)
                            lcgrbd_pkg::OP_SEED: begin
                                lcg_reg <= SB'(s_seed_value ^ mult_reg);
                                st_reg  <= ST_OUT;
                            end
                            lcgrbd_pkg::OP_BITS, lcgrbd_pkg::OP_INT,
                            lcgrbd_pkg::OP_LONG: begin
                                st_reg <= ST_MUL;
                            end
                            lcgrbd_pkg::OP_BOUND: begin
                                if (s_bound <= 0) begin
                                    bad_reg <= 1'b1;
                                    st_reg  <= ST_OUT;
                                end else begin
                                    st_reg <= ST_MUL;
                                end
                            end
                            default: begin
                                st_reg <= ST_OUT;
                            end
                        endcase
                    end
                end
                // one multiplier bit per cycle
                ST_MUL: begin
                    if (mplier_reg[0]) begin
                        acc_reg <= acc_reg + mcand_reg;
                    end
                    mcand_reg  <= mcand_reg << 1;
                    mplier_reg <= mplier_reg >> 1;
                    mcnt_reg   <= mcnt_reg + SW'(1);
                    if (mcnt_reg == SW'(47)) begin
                        st_reg <= ST_ADD;
                    end
                end
                ST_ADD: begin
                    lcg_reg <= acc_reg + SB'(addend_reg);
                    st_reg  <= ST_POST;
                end
                // pick the result of the fresh draw
                ST_POST: begin
                    acc_reg    <= '0;
                    mcand_reg  <= lcg_reg;
                    mplier_reg <= mult_reg;
                    mcnt_reg   <= '0;
                    case (op_reg)
                        lcgrbd_pkg::OP_BITS: begin
                            value_reg <= {{32{bits_val[31]}}, bits_val};
                            st_reg    <= ST_OUT;
                        end
                        lcgrbd_pkg::OP_INT: begin
                            value_reg <= {{32{top32[31]}}, top32};
                            st_reg    <= ST_OUT;
                        end
                        lcgrbd_pkg::OP_LONG: begin
                            if (!second_reg) begin
                                hi_reg     <= top32;
                                second_reg <= 1'b1;
                                st_reg     <= ST_MUL;
                            end else begin
                                value_reg <= {hi_reg, 32'd0}
                                    + {{32{top32[31]}}, top32};
                                st_reg <= ST_OUT;
                            end
                        end
                        default: begin
                            if (bound_pow2) begin
                                value_reg <= 64'(({32'd0, bound_reg}
                                    * {33'd0, top31}) >> 31);
                                st_reg <= ST_OUT;
                            end else begin
                                u_reg    <= top31;
                                quo_reg  <= top31;
                                rem_reg  <= '0;
                                dcnt_reg <= '0;
                                st_reg   <= ST_DIV;
                            end
                        end
                    endcase
                end
                // restoring division, one quotient bit per cycle
                ST_DIV: begin
                    rem_reg  <= rem_sub;
                    quo_reg  <= quo_reg << 1;
                    dcnt_reg <= dcnt_reg + 5'd1;
                    if (dcnt_reg == 5'd30) begin
                        st_reg <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if (!chk[31] || draws_reg == DW'(lcgrbd_pkg::MAX_DRAWS)) begin
                        value_reg <= {32'd0, rem_reg};
                        st_reg    <= ST_OUT;
                    end else begin
                        draws_reg <= draws_reg + DW'(1);
                        st_reg    <= ST_MUL;
                    end
                end
                ST_OUT: begin
                    mvalid_reg <= 1'b1;
                    st_reg     <= ST_IDLE;
                end
                default: begin
                    st_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: design/lcgrbd_checker.sv
// ----------------------------------------------------------------------------
// lcgrbd_checker: port-level checks for the bounded-draw LCG unit
// Watches handshakes and result fields at the top-level ports.
// ----------------------------------------------------------------------------
module lcgrbd_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic [2:0]         s_op,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [63:0] m_value,
    input logic               m_bad_bound
);

    // a stalled result item holds its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value) && $stable(m_bad_bound))
        else $error("result changed while stalled");

    // no new item while a result waits
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input taken with result pending");

    // bad bound flag comes with a zero value
    a_bad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bad_bound |-> m_value == 64'sd0)
        else $error("bad bound with nonzero value");

    // seeding passes through the output state and returns a zero value
    a_seed: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_op == lcgrbd_pkg::OP_SEED
            |-> ##2 m_valid && m_value == 64'sd0)
        else $error("seed result wrong");

endmodule

bind lcg_random_with_bounded_draw_unit lcgrbd_checker u_lcgrbd_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_op        (s_op),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_value     (m_value),
    .m_bad_bound (m_bad_bound)
);

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the 48-bit LCG bounded-draw unit
// Drives seed/draw items with random idling on both sides, predicts every
// result from a local model of the generator and compares field by field.
// Registers are rewritten between phases, including degenerate settings.
// ----------------------------------------------------------------------------
module tb;

    localparam int DRAW_LIMIT = 4096;

    typedef struct {
        logic [2:0]  op;
        logic [47:0] seed;
        logic [5:0]  bits;
        logic [31:0] bound;
        bit          typed;
        logic [63:0] value;
        logic        bad;
    } stim_row_t;

    typedef struct {
        logic [63:0] value;
        logic        bad;
    } draw_result_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [2:0]         s_op;
    logic [47:0]        s_seed_value;
    logic [5:0]         s_bit_count;
    logic signed [31:0] s_bound;
    logic               m_valid;
    logic               m_ready;
    logic signed [63:0] m_value;
    logic               m_bad_bound;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [0:0]         cfg_index;
    logic [47:0]        cfg_data;

    // predictor copy of the generator
    logic [47:0] gen_state;
    logic [47:0] gen_mult;
    logic [47:0] gen_addend;

    draw_result_t pending_draws[$];
    int           err_count;
    int           send_idle;
    int           recv_idle;

    // typed expectation traveling with the current item
    bit           row_typed;
    logic [63:0]  row_value;
    logic         row_bad;

    lcg_random_with_bounded_draw_unit DUT (.*);

    // clock
    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // advance the generator and return its top bits
    function automatic logic [31:0] lcg_draw(int unsigned nbits);
        logic [47:0] prod;
        prod      = gen_state * gen_mult;
        gen_state = prod + gen_addend;
        if (nbits == 0) return 32'd0;
        if (nbits > 32) nbits = 32;
        return 32'(gen_state >> (48 - nbits));
    endfunction

    function automatic logic [63:0] sext(logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    function automatic draw_result_t predict_draw(logic [2:0] op, logic [47:0] seed,
                                                  logic [5:0] nbits, logic [31:0] b);
        draw_result_t res;
        logic [31:0]  hi, lo, lim, r, u, t;
        logic [63:0]  prod;
        int unsigned  n;
        res = '{value: 64'd0, bad: 1'b0};
        case (op)
            lcgrbd_pkg::OP_SEED:  gen_state = seed ^ gen_mult;
            lcgrbd_pkg::OP_BITS:  res.value = sext(lcg_draw(nbits));
            lcgrbd_pkg::OP_INT:   res.value = sext(lcg_draw(32));
            lcgrbd_pkg::OP_LONG: begin
                hi = lcg_draw(32);
                lo = lcg_draw(32);
                res.value = {hi, 32'd0} + sext(lo);
            end
            lcgrbd_pkg::OP_BOUND: begin
                if (b == 32'd0 || b[31]) begin
                    res.bad = 1'b1;
                end else begin
                    lim = b - 32'd1;
                    r   = lcg_draw(31);
                    if ((b & lim) == 32'd0) begin
                        prod = {32'd0, b} * {32'd0, r};
                        r    = 32'(prod >> 31);
                    end else begin
                        u = r;
                        n = 1;
                        forever begin
                            r = u % b;
                            t = u - r + lim;
                            if (!t[31]) break;
                            if (n >= DRAW_LIMIT) break;
                            u = lcg_draw(31);
                            n++;
                        end
                    end
                    res.value = {32'd0, r};
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // result check, then prediction of newly accepted items and registers
    always @(posedge aclk) begin
        draw_result_t got, want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = '{value: m_value, bad: m_bad_bound};
                if (pending_draws.size() == 0) begin
                    $error("result with nothing expected: value %h", got.value);
                    err_count++;
                end else begin
                    want = pending_draws.pop_front();
                    if (got.value !== want.value) begin
                        $error("value: expected %h actual %h", want.value, got.value);
                        err_count++;
                    end
                    if (got.bad !== want.bad) begin
                        $error("bad_bound: expected %b actual %b", want.bad, got.bad);
                        err_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                want = predict_draw(s_op, s_seed_value, s_bit_count, s_bound);
                if (row_typed) want = '{value: row_value, bad: row_bad};
                pending_draws.push_back(want);
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == lcgrbd_pkg::REG_MULT) gen_mult = cfg_data;
                else gen_addend = cfg_data;
            end
        end
    end

    // receiver readiness
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic send_item(stim_row_t row);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_op         <= row.op;
        s_seed_value <= row.seed;
        s_bit_count  <= row.bits;
        s_bound      <= row.bound;
        row_typed    <= row.typed;
        row_value    <= row.value;
        row_bad      <= row.bad;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [47:0] data);
        s_valid <= 1'b0;
        while (pending_draws.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic stim_row_t rand_row();
        stim_row_t row;
        int unsigned pick;
        pick = $urandom_range(99);
        row.seed  = 48'({$urandom, $urandom});
        row.bits  = 6'($urandom_range(63));
        row.typed = 1'b0;
        row.value = '0;
        row.bad   = 1'b0;
        if (pick < 8)       row.op = lcgrbd_pkg::OP_SEED;
        else if (pick < 25) row.op = lcgrbd_pkg::OP_BITS;
        else if (pick < 40) row.op = lcgrbd_pkg::OP_INT;
        else if (pick < 55) row.op = lcgrbd_pkg::OP_LONG;
        else if (pick < 97) row.op = lcgrbd_pkg::OP_BOUND;
        else                row.op = 3'($urandom_range(5, 7));
        case ($urandom_range(4))
            0: row.bound = $urandom;
            1: row.bound = 32'(1) << $urandom_range(31);
            2: row.bound = $urandom_range(1, 100);
            3: row.bound = 32'h4000_0000 + $urandom_range(1, 32'h3FFF_FFFF);
            default: row.bound = $urandom_range(1, 32'h7FFF_FFFF);
        endcase
        return row;
    endfunction

    task automatic send_random(int count);
        repeat (count) send_item(rand_row());
    endtask

    // directed rows; typed value where it is obvious
    stim_row_t directed[] = '{
        '{lcgrbd_pkg::OP_BOUND, 48'd0, 6'd0, 32'd0,         1'b1, 64'd0, 1'b1},
        '{lcgrbd_pkg::OP_BOUND, 48'd0, 6'd0, 32'h8000_0000, 1'b1, 64'd0, 1'b1},
        '{lcgrbd_pkg::OP_BOUND, 48'd0, 6'd0, 32'hFFFF_FFFF, 1'b1, 64'd0, 1'b1},
        '{3'd5, 48'd0, 6'd0, 32'd5,                          1'b1, 64'd0, 1'b0},
        '{3'd6, 48'hFFFF_FFFF_FFFF, 6'd63, 32'hFFFF_FFFF,    1'b1, 64'd0, 1'b0},
        '{3'd7, 48'd0, 6'd0, 32'd0,                          1'b1, 64'd0, 1'b0},
        '{lcgrbd_pkg::OP_INT,   48'd0, 6'd0, 32'd0,         1'b0, 64'd0, 1'b0},
        '{lcgrbd_pkg::OP_BITS,  48'd0, 6'd0, 32'd0,         1'b1, 64'd0, 1'b0},
        '{lcgrbd_pkg::OP_SEED,  48'd0, 6'd0, 32'd0,         1'b1, 64'd0, 1'b0},
        '{lcgrbd_pkg::OP_BITS,  48'd0, 6'd1, 32'd0,         1'b0, 64'd0, 1'b0},
        '{lcgrbd_pkg::OP_BITS,  48'd0, 6'd32, 32'd0,        1'b0, 64'd0, 1'b0},
        '{lcgrbd_pkg::OP_BITS,  48'd0, 6'd33, 32'd0,        1'b0, 64'd0, 1'b0},
        '{lcgrbd_pkg::OP_BITS,  48'd0, 6'd63, 32'd0,        1'b0, 64'd0, 1'b0},
        '{lcgrbd_pkg::OP_LONG,  48'd0, 6'd0, 32'd0,         1'b0, 64'd0, 1'b0},
        '{lcgrbd_pkg::OP_SEED,  48'hFFFF_FFFF_FFFF, 6'd0, 32'd0, 1'b1, 64'd0, 1'b0},
        '{lcgrbd_pkg::OP_INT,   48'd0, 6'd0, 32'd0,         1'b0, 64'd0, 1'b0},
        '{lcgrbd_pkg::OP_BOUND, 48'd0, 6'd0, 32'd1,         1'b0, 64'd0, 1'b0},
        '{lcgrbd_pkg::OP_BOUND, 48'd0, 6'd0, 32'h4000_0000, 1'b0, 64'd0, 1'b0},
        '{lcgrbd_pkg::OP_BOUND, 48'd0, 6'd0, 32'h7FFF_FFFF, 1'b0, 64'd0, 1'b0},
        '{lcgrbd_pkg::OP_BOUND, 48'd0, 6'd0, 32'd3,         1'b0, 64'd0, 1'b0},
        '{lcgrbd_pkg::OP_BOUND, 48'd0, 6'd0, 32'h4000_0001, 1'b0, 64'd0, 1'b0},
        '{lcgrbd_pkg::OP_LONG,  48'd0, 6'd0, 32'd0,         1'b0, 64'd0, 1'b0}
    };

    // main sequence
    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_op         = lcgrbd_pkg::OP_SEED;
        s_seed_value = '0;
        s_bit_count  = '0;
        s_bound      = '0;
        m_ready      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = lcgrbd_pkg::REG_MULT;
        cfg_data     = '0;
        row_typed    = 1'b0;
        row_value    = '0;
        row_bad      = 1'b0;
        gen_state    = '0;
        gen_mult     = lcgrbd_pkg::MULT_RESET;
        gen_addend   = lcgrbd_pkg::ADDEND_RESET;
        err_count    = 0;
        send_idle    = 16;
        recv_idle    = 59;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset settings: directed rows, then random
        foreach (directed[i]) send_item(directed[i]);
        send_random(650);

        // all-ones registers, idling swapped
        send_idle = 59;
        recv_idle = 16;
        write_reg(lcgrbd_pkg::REG_MULT, 48'hFFFF_FFFF_FFFF);
        write_reg(lcgrbd_pkg::REG_ADDEND, 48'hFFFF_FFFF_FFFF);
        send_random(550);

        // stuck generator: bounded draw rejects until the draw limit
        write_reg(lcgrbd_pkg::REG_MULT, 48'd1);
        write_reg(lcgrbd_pkg::REG_ADDEND, 48'd0);
        send_item('{lcgrbd_pkg::OP_SEED, 48'hFFFF_FFFF_FFFE, 6'd0, 32'd0,
                    1'b1, 64'd0, 1'b0});
        send_item('{lcgrbd_pkg::OP_BOUND, 48'd0, 6'd0, 32'h4000_0001,
                    1'b0, 64'd0, 1'b0});
        send_item('{lcgrbd_pkg::OP_INT, 48'd0, 6'd0, 32'd0, 1'b0, 64'd0, 1'b0});

        // zero registers
        write_reg(lcgrbd_pkg::REG_MULT, 48'd0);
        write_reg(lcgrbd_pkg::REG_ADDEND, 48'd0);
        send_random(40);

        // random registers, no idling, then the reset values again
        send_idle = 0;
        recv_idle = 0;
        write_reg(lcgrbd_pkg::REG_MULT, 48'({$urandom, $urandom}));
        write_reg(lcgrbd_pkg::REG_ADDEND, 48'({$urandom, $urandom}));
        send_random(400);
        write_reg(lcgrbd_pkg::REG_MULT, lcgrbd_pkg::MULT_RESET);
        write_reg(lcgrbd_pkg::REG_ADDEND, lcgrbd_pkg::ADDEND_RESET);
        send_random(350);

        s_valid <= 1'b0;
        while (pending_draws.size() != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // run limit
    initial begin
        #50ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: filelist.f
design/lcgrbd_pkg.sv
design/lcg_random_with_bounded_draw_unit.sv
design/lcgrbd_checker.sv
tb/tb.sv
